/* rtl/bbd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbd_pkg
// Shared types and constants of the bilinear Bayer demosaic.
// ----------------------------------------------------------------------------
package bbd_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int DIM_W      = 13;
  localparam int ROW_W      = 12;

  localparam logic [DIM_W-1:0] MIN_DIM         = 13'd3;
  localparam logic [DIM_W-1:0] MAX_HEIGHT      = 13'd4096;
  localparam logic [DIM_W-1:0] LINE_WIDTH_RST  = 13'd4096;
  localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 13'd3072;

  // Row and column phase of the red site, indexed by the mosaic phase
  // (RGGB, BGGR, GRBG, GBRG).
  localparam logic [3:0] RED_ROW = 4'b1010;
  localparam logic [3:0] RED_COL = 4'b0110;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BAYER_PATTERN = 2'd0,
    CFG_LINE_WIDTH    = 2'd1,
    CFG_FRAME_HEIGHT  = 2'd2
  } cfg_idx_e;

  // Per-word control worked out at acceptance and carried to the pixel stage.
  typedef struct packed {
    logic emit;      // word gives a pixel
    logic last_col;  // pixel is the last column of the line before
    logic left_mir;  // left neighbours mirror from the right
    logic top_mir;   // top row mirrors from the bottom
    logic bot_mir;   // bottom row mirrors from the top
    logic row_odd;
    logic col_odd;
    logic frame_end;
    logic fwd;       // line store data comes from the word just written
  } bbd_ctrl_t;

endpackage

/* rtl/bayer_bilinear_demosaic_top.sv */
`timescale 1ns / 1ps
// Path: an accepted word passes the pixel stage and output registers; pixels lag the
//   raw stream by line_width + 1 words. Throughput: one word per cycle without output
//   stall, set by the single registered read port of each line store. Reset clears
//   counters, window and valid flags, presets the config; line stores are not cleared.
// ----------------------------------------------------------------------------
// bayer_bilinear_demosaic_top
// Streaming 3x3 bilinear demosaic: two line stores, a window and a pixel stage.
// ----------------------------------------------------------------------------
module bayer_bilinear_demosaic_top
  import bbd_pkg::*;
#(
  parameter int MAX_WIDTH  = 4096,
  parameter int PIXEL_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [15:0]           s_axis_tdata,  // raw_sample
  input  logic                  s_axis_tuser,  // flush
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [47:0]           m_axis_tdata,  // red, green, blue
  output logic                  m_axis_tlast,  // line_end
  output logic                  m_axis_tuser   // frame_end
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int CMPW = (WW > DIM_W) ? WW : DIM_W;
  localparam int PB   = PIXEL_BITS;

  // configuration
  logic [1:0]       pattern_q;
  logic [DIM_W-1:0] line_width_q;
  logic [DIM_W-1:0] frame_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q      <= '0;
      line_width_q   <= LINE_WIDTH_RST;
      frame_height_q <= FRAME_HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_BAYER_PATTERN: pattern_q      <= cfg_wdata_i[1:0];
        CFG_LINE_WIDTH:    line_width_q   <= cfg_wdata_i;
        CFG_FRAME_HEIGHT:  frame_height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic [CMPW-1:0]  lw_ext;
  logic [CMPW-1:0]  w_full;
  logic [WW-1:0]    w;
  logic [DIM_W-1:0] h;

  always_comb begin
    lw_ext = CMPW'(line_width_q);
    if (lw_ext < CMPW'(MIN_DIM)) begin
      w_full = CMPW'(MIN_DIM);
    end else if (lw_ext > CMPW'(MAX_WIDTH)) begin
      w_full = CMPW'(MAX_WIDTH);
    end else begin
      w_full = lw_ext;
    end
    w = w_full[WW-1:0];
    if (frame_height_q < MIN_DIM) begin
      h = MIN_DIM;
    end else if (frame_height_q > MAX_HEIGHT) begin
      h = MAX_HEIGHT;
    end else begin
      h = frame_height_q;
    end
  end

  // --------------------------------------------------------------------------
  // Acceptance: position, drop decision and pixel control
  // --------------------------------------------------------------------------
  logic [CW-1:0]    col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic             tp_q, tp_d;

  logic             s1_valid_q;
  bbd_ctrl_t        s1_ctrl_q;
  logic [CW-1:0]    s1_col_q;
  logic [PB-1:0]    s1_pix_q;
  logic [PB-1:0]    fwd_top_q, fwd_mid_q;
  logic             s1_go;

  logic             o_valid_q;
  logic             acc, keep, flush;
  logic [CW-1:0]    k;
  logic [ROW_W-1:0] r;
  logic [DIM_W-1:0] r_ext, crow;
  logic [WW-1:0]    k_ext, k_nxt;
  logic [DIM_W-1:0] r_nxt;
  logic             k_is0, first, second, drop;
  bbd_ctrl_t        ctrl_d;

  assign flush = s_axis_tuser;
  assign acc   = s_axis_tvalid && s_axis_tready;

  always_comb begin
    k     = (WW'(col_q) >= w) ? '0 : col_q;
    r     = (DIM_W'(row_q) >= h) ? '0 : row_q;
    k_ext = WW'(k);
    r_ext = DIM_W'(r);
    k_is0 = (k == '0);

    first  = k_is0 && ((r_ext >= DIM_W'(2)) || tp_q);
    second = !k_is0 && ((r_ext >= DIM_W'(1)) || tp_q);
    drop   = flush && !(tp_q && ((r_ext == '0) || ((r_ext == DIM_W'(1)) && k_is0)));

    if (first) begin
      if (r_ext >= DIM_W'(2)) begin
        crow = r_ext - DIM_W'(2);
      end else if (r_ext == DIM_W'(1)) begin
        crow = h - DIM_W'(1);
      end else begin
        crow = h - DIM_W'(2);
      end
    end else begin
      crow = (r_ext >= DIM_W'(1)) ? r_ext - DIM_W'(1) : h - DIM_W'(1);
    end

    ctrl_d.emit      = first || second;
    ctrl_d.last_col  = first;
    ctrl_d.left_mir  = !first && (k_ext == WW'(1));
    ctrl_d.top_mir   = (crow == '0);
    ctrl_d.bot_mir   = (crow == h - DIM_W'(1));
    ctrl_d.row_odd   = crow[0];
    ctrl_d.col_odd   = first ? ~w[0] : ~k[0];
    ctrl_d.frame_end = first && (crow == h - DIM_W'(1));
    ctrl_d.fwd       = s1_go && (k == s1_col_q);

    // advance the position; a flush that ends the frame restarts it
    tp_d  = tp_q;
    col_d = col_q;
    row_d = row_q;
    k_nxt = k_ext + WW'(1);
    r_nxt = r_ext + DIM_W'(1);
    if (ctrl_d.frame_end) begin
      tp_d = 1'b0;
    end
    if (flush && ctrl_d.frame_end) begin
      col_d = '0;
      row_d = '0;
    end else begin
      if ((r_ext == h - DIM_W'(1)) && (k_ext == w - WW'(1))) begin
        tp_d = 1'b1;
      end
      if (k_nxt >= w) begin
        col_d = '0;
        row_d = (r_nxt >= h) ? '0 : r_nxt[ROW_W-1:0];
      end else begin
        col_d = k_nxt[CW-1:0];
        row_d = r;
      end
    end
  end

  assign keep = acc && !drop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      tp_q  <= 1'b0;
    end else if (keep) begin
      col_q <= col_d;
      row_q <= row_d;
      tp_q  <= tp_d;
    end else if (acc) begin
      // wrap a position beyond the current size even for a dropped flush
      col_q <= k;
      row_q <= r;
    end
  end

  // --------------------------------------------------------------------------
  // Line stores
  // --------------------------------------------------------------------------
  logic [PB-1:0] rd_a, rd_b;
  logic [PB-1:0] top_v, mid_v;

  bbd_ram #(.WIDTH(PB), .DEPTH(MAX_WIDTH)) u_store_a (
    .clk_i   (clk_i),
    .we_i    (s1_go),
    .waddr_i (s1_col_q),
    .wdata_i (mid_v),
    .re_i    (keep),
    .raddr_i (k),
    .rdata_o (rd_a)
  );

  bbd_ram #(.WIDTH(PB), .DEPTH(MAX_WIDTH)) u_store_b (
    .clk_i   (clk_i),
    .we_i    (s1_go),
    .waddr_i (s1_col_q),
    .wdata_i (s1_pix_q),
    .re_i    (keep),
    .raddr_i (k),
    .rdata_o (rd_b)
  );

  // --------------------------------------------------------------------------
  // Pixel stage: window shift and interpolation
  // --------------------------------------------------------------------------
  assign s1_go         = s1_valid_q && (!s1_ctrl_q.emit || !o_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_ctrl_q  <= '0;
    end else if (s_axis_tready) begin
      s1_valid_q <= keep;
      s1_ctrl_q  <= ctrl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (keep) begin
      s1_col_q <= k;
      s1_pix_q <= flush ? '0 : s_axis_tdata[PB-1:0];
    end
    if (s1_go) begin
      fwd_top_q <= mid_v;
      fwd_mid_q <= s1_pix_q;
    end
  end

  logic [PB-1:0]   win_q [3][3];
  logic [PB-1:0]   new_col [3];
  logic [PB-1:0]   nb [3][3];
  logic [PB-1:0]   nbm [3][3];
  logic [PB+1:0]   orth, diag;
  logic [PB:0]     hor_s, ver_s;
  logic [PB-1:0]   c_v, orth_v, diag_v, hor_v, ver_v;
  logic [PB-1:0]   red_v, green_v, blue_v;
  logic            in_red_row, in_red_col;

  always_comb begin
    top_v = s1_ctrl_q.fwd ? fwd_top_q : rd_a;
    mid_v = s1_ctrl_q.fwd ? fwd_mid_q : rd_b;
    new_col[0] = top_v;
    new_col[1] = mid_v;
    new_col[2] = s1_pix_q;
    for (int i = 0; i < 3; i++) begin
      nb[i][1] = win_q[i][2];
      nb[i][2] = s1_ctrl_q.last_col ? win_q[i][1] : new_col[i];
      nb[i][0] = s1_ctrl_q.left_mir ? nb[i][2] : win_q[i][1];
    end
    for (int j = 0; j < 3; j++) begin
      nbm[0][j] = s1_ctrl_q.top_mir ? nb[2][j] : nb[0][j];
      nbm[1][j] = nb[1][j];
      nbm[2][j] = s1_ctrl_q.bot_mir ? nb[0][j] : nb[2][j];
    end

    c_v    = nbm[1][1];
    orth   = (PB+2)'(nbm[0][1]) + (PB+2)'(nbm[2][1]) + (PB+2)'(nbm[1][0])
           + (PB+2)'(nbm[1][2]);
    diag   = (PB+2)'(nbm[0][0]) + (PB+2)'(nbm[0][2]) + (PB+2)'(nbm[2][0])
           + (PB+2)'(nbm[2][2]);
    hor_s  = (PB+1)'(nbm[1][0]) + (PB+1)'(nbm[1][2]);
    ver_s  = (PB+1)'(nbm[0][1]) + (PB+1)'(nbm[2][1]);
    orth_v = orth[PB+1:2];
    diag_v = diag[PB+1:2];
    hor_v  = hor_s[PB:1];
    ver_v  = ver_s[PB:1];

    in_red_row = (s1_ctrl_q.row_odd == RED_ROW[pattern_q]);
    in_red_col = (s1_ctrl_q.col_odd == RED_COL[pattern_q]);
    if (in_red_row && in_red_col) begin
      red_v = c_v;   green_v = orth_v; blue_v = diag_v;
    end else if (!in_red_row && !in_red_col) begin
      blue_v = c_v;  green_v = orth_v; red_v = diag_v;
    end else if (in_red_row) begin
      green_v = c_v; red_v = hor_v;    blue_v = ver_v;
    end else begin
      green_v = c_v; blue_v = hor_v;   red_v = ver_v;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_q[i][j] <= '0;
        end
      end
    end else if (s1_go) begin
      for (int i = 0; i < 3; i++) begin
        win_q[i][0] <= win_q[i][1];
        win_q[i][1] <= win_q[i][2];
        win_q[i][2] <= new_col[i];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic [15:0] o_red_q, o_green_q, o_blue_q;
  logic        o_line_end_q, o_frame_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else if (s1_go && s1_ctrl_q.emit) begin
      o_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      o_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && s1_ctrl_q.emit) begin
      o_red_q       <= 16'(red_v);
      o_green_q     <= 16'(green_v);
      o_blue_q      <= 16'(blue_v);
      o_line_end_q  <= s1_ctrl_q.last_col;
      o_frame_end_q <= s1_ctrl_q.frame_end;
    end
  end

  assign m_axis_tvalid = o_valid_q;
  assign m_axis_tdata  = {o_blue_q, o_green_q, o_red_q};
  assign m_axis_tlast  = o_line_end_q;
  assign m_axis_tuser  = o_frame_end_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_frame_end_is_line_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("frame end without line end");

  a_tail_clears_on_frame_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(tp_q) |-> $past(keep && ctrl_d.frame_end))
    else $error("tail flag dropped without a frame end pixel");

  a_pixel_stage_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_go |=> s1_valid_q && $stable(s1_col_q))
    else $error("stalled word lost from pixel stage");

  a_ready_only_when_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> s1_valid_q && s1_ctrl_q.emit && o_valid_q)
    else $error("input stalled with room in the pipeline");

endmodule

/* rtl/bbd_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbd_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bbd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
